### sv/assert_macros.svh
// Assertion helpers for the decompressor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent implies consequent on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// Types and constants for the flag-word LZSS decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

    typedef enum logic [3:0] {
        PH_TYPE, PH_KIND, PH_SLEN_HI, PH_SLEN_LO, PH_SDIST,
        PH_LIT, PH_LB1, PH_LB2, PH_LEXT
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,    // waiting for an input byte
        ST_BITS,    // consuming flag bits, one per cycle
        ST_BYTE,    // acting on the byte
        ST_COPY,    // copying match bytes, each read from the window, then written
        ST_EMIT     // result waiting for the output transfer
    } state_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_TRUNC    = 2'd1,
        ERR_OVERFLOW = 2'd2,
        ERR_DIST     = 2'd3
    } err_t;

    localparam logic [7:0]  XOR_KEY_RESET  = 8'hAD;
    localparam logic [15:0] OUT_LIMIT_RESET = 16'd32768;
    localparam logic [0:0]  REG_XOR_KEY    = 1'b0;
    localparam logic [0:0]  REG_OUT_LIMIT  = 1'b1;

endpackage

### sv/lzss_flagword_decompressor_unit.sv
// ----------------------------------------------------------------------------
// lzss_flagword_decompressor_unit
// Byte-serial LZSS decoder with 16-bit flag words and up to four bytes a result.
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid, in_stall, data_byte, last_byte | in, stall out
//  out     | out_valid, out_stall, out_byte0..total_out| out, stall in
//  cfg     | cfg_we, cfg_index, cfg_data              | in
//
// An input byte passes through accept, flag-bit check, byte decode and final
// emit; the check first uses the pending flag bits before it (at most 4), one
// at a time. A match copies each byte by a registered window read and then
// a write, with an emit for each full group of four handed off mid-copy.
// Every output transfer waits out its stalls on top of that.
// Reset is asynchronous and clears control state; the window is never cleared.
// in_stall stays high from acceptance until the last result, if any, has transferred.
// A stalled result holds its payload, and the copy stalls with it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lzss_flagword_decompressor_unit #(
    parameter int WINDOW_DEPTH = 8192,
    parameter int MAX_OUTPUT   = 32768
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte0,
    output logic [7:0]  out_byte1,
    output logic [7:0]  out_byte2,
    output logic [7:0]  out_byte3,
    output logic [2:0]  byte_count,
    output logic        run_end,
    output logic        stream_done,
    output logic [1:0]  error_code,
    output logic [15:0] total_out
);
    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam logic [16:0] MAX_OUT = 17'(MAX_OUTPUT);

    logic [7:0] window_mem [WINDOW_DEPTH];

    lzss_pkg::state_t state_reg, state_next;
    lzss_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  key_reg;
    logic [15:0] limit_reg;
    logic [15:0] flag_reg, flag_next;
    logic [4:0]  left_reg, left_next;
    logic        high_due_reg, high_due_next;
    logic [7:0]  pend_reg, pend_next;
    logic [8:0]  len_reg, len_next;
    logic [13:0] dist_reg, dist_next;
    logic [15:0] wcnt_reg, wcnt_next;
    logic        fin_reg, fin_next;
    logic [1:0]  err_reg, err_next;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [7:0]  grp_reg [4];
    logic [7:0]  grp_next [4];
    logic [2:0]  gcnt_reg, gcnt_next;
    logic        rd_pend_reg, rd_pend_next;  // window read data valid next cycle
    logic [7:0]  rd_data_reg;
    logic        tail_reg, tail_next;        // emit is the final result
    logic        resume_reg, resume_next;    // return to copy after emit
    logic        any_reg, any_next;          // some byte was produced this input

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  wdata;
    logic        re;
    logic [16:0] lim;

    always_comb
    begin
        lim = (17'(limit_reg) > MAX_OUT) ? MAX_OUT : 17'(limit_reg);
    end

    always_ff @(posedge clk)
    begin
        if (we)
            window_mem[waddr] <= wdata;
        if (re)
            rd_data_reg <= window_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= lzss_pkg::XOR_KEY_RESET;
            limit_reg <= lzss_pkg::OUT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == lzss_pkg::REG_XOR_KEY)
                key_reg <= cfg_data[7:0];
            else
                limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= lzss_pkg::ST_IDLE;
            phase_reg    <= lzss_pkg::PH_TYPE;
            flag_reg     <= '0;
            left_reg     <= '0;
            high_due_reg <= 1'b0;
            pend_reg     <= '0;
            len_reg      <= '0;
            dist_reg     <= '0;
            wcnt_reg     <= '0;
            fin_reg      <= 1'b0;
            err_reg      <= lzss_pkg::ERR_NONE;
            gcnt_reg     <= '0;
            rd_pend_reg  <= 1'b0;
            tail_reg     <= 1'b0;
            resume_reg   <= 1'b0;
            any_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            flag_reg     <= flag_next;
            left_reg     <= left_next;
            high_due_reg <= high_due_next;
            pend_reg     <= pend_next;
            len_reg      <= len_next;
            dist_reg     <= dist_next;
            wcnt_reg     <= wcnt_next;
            fin_reg      <= fin_next;
            err_reg      <= err_next;
            gcnt_reg     <= gcnt_next;
            rd_pend_reg  <= rd_pend_next;
            tail_reg     <= tail_next;
            resume_reg   <= resume_next;
            any_reg      <= any_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == lzss_pkg::ST_IDLE && in_valid)
        begin
            byte_reg <= data_byte ^ key_reg;
            last_reg <= last_byte;
        end
        grp_reg <= grp_next;
    end

    // Main sequencer
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        flag_next     = flag_reg;
        left_next     = left_reg;
        high_due_next = high_due_reg;
        pend_next     = pend_reg;
        len_next      = len_reg;
        dist_next     = dist_reg;
        wcnt_next     = wcnt_reg;
        fin_next      = fin_reg;
        err_next      = err_reg;
        grp_next      = grp_reg;
        gcnt_next     = gcnt_reg;
        rd_pend_next  = 1'b0;
        tail_next     = tail_reg;
        resume_next   = resume_reg;
        any_next      = any_reg;
        we            = 1'b0;
        waddr         = wcnt_reg[AW-1:0];
        wdata         = byte_reg;
        re            = 1'b0;
        raddr         = AW'(wcnt_reg - 16'(dist_reg));

        case (state_reg)
            lzss_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    gcnt_next   = '0;
                    any_next    = 1'b0;
                    resume_next = 1'b0;
                    if (fin_reg)
                    begin
                        tail_next  = 1'b1;
                        state_next = lzss_pkg::ST_EMIT;
                    end
                    else
                        state_next = lzss_pkg::ST_BITS;
                end
            end

            lzss_pkg::ST_BITS:
            begin
                if (left_reg != 5'd0 && (phase_reg inside {lzss_pkg::PH_TYPE,
                    lzss_pkg::PH_KIND, lzss_pkg::PH_SLEN_HI, lzss_pkg::PH_SLEN_LO}))
                begin
                    flag_next = {1'b0, flag_reg[15:1]};
                    left_next = left_reg - 5'd1;
                    case (phase_reg)
                        lzss_pkg::PH_TYPE:
                            phase_next = flag_reg[0] ? lzss_pkg::PH_LIT : lzss_pkg::PH_KIND;
                        lzss_pkg::PH_KIND:
                            phase_next = flag_reg[0] ? lzss_pkg::PH_LB1
                                                     : lzss_pkg::PH_SLEN_HI;
                        lzss_pkg::PH_SLEN_HI:
                        begin
                            len_next   = {8'd0, flag_reg[0]};
                            phase_next = lzss_pkg::PH_SLEN_LO;
                        end
                        default:
                        begin
                            len_next   = {len_reg[7:0], flag_reg[0]} + 9'd2;
                            phase_next = lzss_pkg::PH_SDIST;
                        end
                    endcase
                end
                else
                    state_next = lzss_pkg::ST_BYTE;
            end

            lzss_pkg::ST_BYTE:
            begin
                state_next = lzss_pkg::ST_EMIT;
                tail_next  = 1'b1;
                if (left_reg == 5'd0)
                begin
                    if (!high_due_reg)
                    begin
                        pend_next     = byte_reg;
                        high_due_next = 1'b1;
                    end
                    else
                    begin
                        flag_next     = {byte_reg, pend_reg};
                        left_next     = 5'd16;
                        high_due_next = 1'b0;
                    end
                end
                else
                begin
                    case (phase_reg)
                        lzss_pkg::PH_LIT:
                        begin
                            phase_next = lzss_pkg::PH_TYPE;
                            if (17'(wcnt_reg) >= lim)
                            begin
                                fin_next = 1'b1;
                                err_next = lzss_pkg::ERR_OVERFLOW;
                            end
                            else
                            begin
                                we          = 1'b1;
                                wcnt_next   = wcnt_reg + 16'd1;
                                grp_next[0] = byte_reg;
                                gcnt_next   = 3'd1;
                                any_next    = 1'b1;
                            end
                        end
                        lzss_pkg::PH_SDIST:
                        begin
                            phase_next = lzss_pkg::PH_TYPE;
                            dist_next  = 14'd256 - 14'(byte_reg);
                            tail_next  = 1'b0;
                            state_next = lzss_pkg::ST_COPY;
                        end
                        lzss_pkg::PH_LB1:
                        begin
                            pend_next  = byte_reg;
                            phase_next = lzss_pkg::PH_LB2;
                        end
                        lzss_pkg::PH_LB2:
                        begin
                            dist_next = 14'd8192 - {1'b0, byte_reg[7:3], pend_reg};
                            len_next  = {6'd0, byte_reg[2:0]} + 9'd2;
                            if (byte_reg[2:0] == 3'd0)
                                phase_next = lzss_pkg::PH_LEXT;
                            else
                            begin
                                phase_next = lzss_pkg::PH_TYPE;
                                tail_next  = 1'b0;
                                state_next = lzss_pkg::ST_COPY;
                            end
                        end
                        lzss_pkg::PH_LEXT:
                        begin
                            phase_next = lzss_pkg::PH_TYPE;
                            if (byte_reg == 8'd0)
                            begin
                                fin_next = 1'b1;
                                err_next = lzss_pkg::ERR_NONE;
                            end
                            else if (byte_reg != 8'd1)
                            begin
                                len_next   = 9'(byte_reg) + 9'd1;
                                tail_next  = 1'b0;
                                state_next = lzss_pkg::ST_COPY;
                            end
                        end
                        default:
                            phase_next = lzss_pkg::PH_TYPE;
                    endcase
                end
                // distance check precedes any copy
                if (state_next == lzss_pkg::ST_COPY && wcnt_reg < 16'(dist_next))
                begin
                    fin_next   = 1'b1;
                    err_next   = lzss_pkg::ERR_DIST;
                    tail_next  = 1'b1;
                    state_next = lzss_pkg::ST_EMIT;
                end
                // end of stream check, once the byte has been consumed
                if (state_next == lzss_pkg::ST_EMIT && !fin_next && last_reg)
                begin
                    fin_next = 1'b1;
                    err_next = (phase_next == lzss_pkg::PH_TYPE && left_next != 5'd0)
                             ? lzss_pkg::ERR_NONE : lzss_pkg::ERR_TRUNC;
                end
            end

            lzss_pkg::ST_COPY:
            begin
                // read then write: the next byte's read starts only after this write
                if (rd_pend_reg)
                begin
                    we          = 1'b1;
                    wdata       = rd_data_reg;
                    wcnt_next   = wcnt_reg + 16'd1;
                    grp_next[gcnt_reg[1:0]] = rd_data_reg;
                    gcnt_next   = gcnt_reg + 3'd1;
                    any_next    = 1'b1;
                    len_next    = len_reg - 9'd1;
                    if (len_reg == 9'd1)
                    begin
                        tail_next  = 1'b1;
                        state_next = lzss_pkg::ST_EMIT;
                        if (last_reg)
                        begin
                            fin_next = 1'b1;
                            err_next = (left_reg != 5'd0) ? lzss_pkg::ERR_NONE
                                                          : lzss_pkg::ERR_TRUNC;
                        end
                    end
                    else if (gcnt_reg == 3'd3)
                    begin
                        // next byte would overflow: this full group ends the input
                        if (17'(wcnt_next) >= lim)
                        begin
                            fin_next   = 1'b1;
                            err_next   = lzss_pkg::ERR_OVERFLOW;
                            tail_next  = 1'b1;
                            state_next = lzss_pkg::ST_EMIT;
                        end
                        else
                        begin
                            resume_next = 1'b1;
                            state_next  = lzss_pkg::ST_EMIT;
                        end
                    end
                end
                else if (17'(wcnt_reg) >= lim)
                begin
                    fin_next   = 1'b1;
                    err_next   = lzss_pkg::ERR_OVERFLOW;
                    tail_next  = 1'b1;
                    state_next = lzss_pkg::ST_EMIT;
                end
                else
                begin
                    re           = 1'b1;
                    rd_pend_next = 1'b1;
                end
            end

            lzss_pkg::ST_EMIT:
            begin
                if (!tail_reg && gcnt_reg == 3'd0)
                    state_next = lzss_pkg::ST_IDLE;
                else if (tail_reg && gcnt_reg == 3'd0 && !fin_reg && !any_reg)
                    state_next = lzss_pkg::ST_IDLE;
                else if (!out_stall)
                begin
                    gcnt_next = '0;
                    grp_next  = '{default: 8'd0};
                    if (resume_reg)
                    begin
                        resume_next = 1'b0;
                        state_next  = lzss_pkg::ST_COPY;
                    end
                    else
                        state_next = lzss_pkg::ST_IDLE;
                end
            end

            default:
                state_next = lzss_pkg::ST_IDLE;
        endcase
    end

    // a tail with no bytes is shown only when the stream has ended
    logic show;
    always_comb
    begin
        show = (state_reg == lzss_pkg::ST_EMIT) &&
               (gcnt_reg != 3'd0 || (tail_reg && fin_reg && !any_reg) ||
                (tail_reg && fin_reg && any_reg && gcnt_reg == 3'd0));
    end

    assign in_stall    = (state_reg != lzss_pkg::ST_IDLE);
    assign out_valid   = show;
    assign out_byte0   = (gcnt_reg > 3'd0) ? grp_reg[0] : 8'd0;
    assign out_byte1   = (gcnt_reg > 3'd1) ? grp_reg[1] : 8'd0;
    assign out_byte2   = (gcnt_reg > 3'd2) ? grp_reg[2] : 8'd0;
    assign out_byte3   = (gcnt_reg > 3'd3) ? grp_reg[3] : 8'd0;
    assign byte_count  = gcnt_reg;
    assign run_end     = !resume_reg;
    assign stream_done = !resume_reg && fin_reg;
    assign error_code  = resume_reg ? lzss_pkg::ERR_NONE : err_reg;
    assign total_out   = wcnt_reg;

    `ASSERT_CLK(a_group_bound, clk, rst_n, gcnt_reg <= 3'd4, "group count above four")
    `ASSERT_CLK(a_out_idle_only_emit, clk, rst_n,
        !out_valid || state_reg == lzss_pkg::ST_EMIT, "result outside emit")
    `ASSERT_NEXT(a_written_held, clk, rst_n,
        state_reg == lzss_pkg::ST_IDLE, wcnt_reg == $past(wcnt_reg),
        "written count moved while idle")
endmodule

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the flag-word LZSS decoder: one long obfuscated
// stream is planned byte by byte, decoded again by a behavioral copy of the
// decoder at each input transfer, and every output transfer is compared
// field by field against the oldest predicted group.
// ----------------------------------------------------------------------------
module tb;

    localparam int WIN = 8192;
    localparam int MAX_OUT = 32768;
    localparam int ROLE_FLAG = -1;      // next byte refills the flag word

    typedef struct {
        logic [7:0]       win [WIN];
        logic [15:0]      fw;
        int               left;
        lzss_pkg::phase_t ph;
        logic [7:0]       plow;
        int               mlen;
        int               mdist;
        int               wcount;
        bit               fin;
        bit               high_due;
        lzss_pkg::err_t   err;
        logic [7:0]       key;
        logic [15:0]      lim;
    } dec_state_t;

    typedef struct packed {
        logic [3:0][7:0] data;
        logic [2:0]      count;
        logic            run_end;
        logic            done;
        logic [1:0]      err;
        logic [15:0]     total;
    } out_group_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } in_item_t;

    typedef enum {END_NONE, END_NORMAL, END_TRUNC, END_MARK, END_DIST, END_OVER} end_mode_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  out_byte0, out_byte1, out_byte2, out_byte3;
    logic [2:0]  byte_count;
    logic        run_end;
    logic        stream_done;
    logic [1:0]  error_code;
    logic [15:0] total_out;

    lzss_flagword_decompressor_unit dut (.*);

    dec_state_t  model;            // tracks the block, updated on input transfers
    dec_state_t  plan;             // tracks the stream as it is being written
    in_item_t    pending_bytes[$];
    out_group_t  expected_groups[$];
    int          pin_dist[$];
    int          pin_len3[$];
    int          pin_ext[$];
    logic [12:0] long_code;
    end_mode_t   end_mode;
    int          fail_count;
    int          cyc;
    int          hold_left;

    // ------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------
    function automatic void clear_state(output dec_state_t s);
        foreach (s.win[i]) s.win[i] = 8'h00;
        s.fw = '0;
        s.left = 0;
        s.ph = lzss_pkg::PH_TYPE;
        s.plow = '0;
        s.mlen = 0;
        s.mdist = 0;
        s.wcount = 0;
        s.fin = 0;
        s.high_due = 0;
        s.err = lzss_pkg::ERR_NONE;
        s.key = lzss_pkg::XOR_KEY_RESET;
        s.lim = lzss_pkg::OUT_LIMIT_RESET;
    endfunction

    function automatic void decode_byte(inout dec_state_t s, input logic [7:0] raw,
                                        input bit last, output out_group_t res[$]);
        logic [7:0] b;
        logic [7:0] produced[$];
        int         count_start;
        int         cap;
        int         n;
        int         groups;
        int         cnt;
        bit         fb;
        bit         copy;
        bit         lit;
        out_group_t g;
        b = raw ^ s.key;
        count_start = s.wcount;
        cap = (s.lim > MAX_OUT) ? MAX_OUT : int'(s.lim);
        res = {};
        copy = 0;
        lit = 0;
        if (!s.fin) begin
            // flag bits are consumed before the byte is looked at
            while (s.left != 0 && s.ph <= lzss_pkg::PH_SLEN_LO) begin
                fb = s.fw[0];
                s.fw = s.fw >> 1;
                s.left--;
                case (s.ph)
                    lzss_pkg::PH_TYPE:
                        s.ph = fb ? lzss_pkg::PH_LIT : lzss_pkg::PH_KIND;
                    lzss_pkg::PH_KIND:
                        s.ph = fb ? lzss_pkg::PH_LB1 : lzss_pkg::PH_SLEN_HI;
                    lzss_pkg::PH_SLEN_HI: begin
                        s.mlen = fb;
                        s.ph = lzss_pkg::PH_SLEN_LO;
                    end
                    default: begin
                        s.mlen = ((s.mlen << 1) | fb) + 2;
                        s.ph = lzss_pkg::PH_SDIST;
                    end
                endcase
            end
            if (s.left == 0) begin
                if (!s.high_due) begin
                    s.plow = b;
                    s.high_due = 1;
                end else begin
                    s.fw = {b, s.plow};
                    s.left = 16;
                    s.high_due = 0;
                end
            end else begin
                case (s.ph)
                    lzss_pkg::PH_LIT: begin s.ph = lzss_pkg::PH_TYPE; lit = 1; end
                    lzss_pkg::PH_SDIST: begin
                        s.ph = lzss_pkg::PH_TYPE;
                        s.mdist = 256 - b;
                        copy = 1;
                    end
                    lzss_pkg::PH_LB1: begin s.plow = b; s.ph = lzss_pkg::PH_LB2; end
                    lzss_pkg::PH_LB2: begin
                        s.mdist = 8192 - (((b & 8'hF8) << 5) | s.plow);
                        s.mlen = b[2:0] + 2;
                        if (b[2:0] == 3'd0) s.ph = lzss_pkg::PH_LEXT;
                        else begin s.ph = lzss_pkg::PH_TYPE; copy = 1; end
                    end
                    lzss_pkg::PH_LEXT: begin
                        s.ph = lzss_pkg::PH_TYPE;
                        if (b == 8'd0) begin s.fin = 1; s.err = lzss_pkg::ERR_NONE; end
                        else if (b != 8'd1) begin s.mlen = b + 1; copy = 1; end
                    end
                    default: s.ph = lzss_pkg::PH_TYPE;
                endcase
            end
            if (lit) begin
                if (s.wcount >= cap) begin s.fin = 1; s.err = lzss_pkg::ERR_OVERFLOW; end
                else begin
                    s.win[s.wcount % WIN] = b;
                    s.wcount++;
                    produced.push_back(b);
                end
            end
            if (copy) begin
                if (s.wcount < s.mdist) begin s.fin = 1; s.err = lzss_pkg::ERR_DIST; end
                else for (int k = 0; k < s.mlen; k++) begin
                    if (s.wcount >= cap) begin
                        s.fin = 1;
                        s.err = lzss_pkg::ERR_OVERFLOW;
                        break;
                    end
                    // bytewise copy, so an overlapping match sees its own output
                    s.win[s.wcount % WIN] = s.win[(s.wcount - s.mdist) % WIN];
                    produced.push_back(s.win[s.wcount % WIN]);
                    s.wcount++;
                end
            end
            if (!s.fin && last) begin
                s.fin = 1;
                s.err = (s.ph == lzss_pkg::PH_TYPE && s.left != 0) ? lzss_pkg::ERR_NONE
                                                                     : lzss_pkg::ERR_TRUNC;
            end
        end
        n = produced.size();
        groups = (n == 0) ? (s.fin ? 1 : 0) : (n + 3) / 4;
        for (int r = 0; r < groups; r++) begin
            g = '0;
            cnt = 0;
            for (int j = 0; j < 4; j++)
                if (r * 4 + j < n) begin
                    g.data[j] = produced[r * 4 + j];
                    cnt++;
                end
            g.count = 3'(cnt);
            g.run_end = (r + 1 == groups);
            g.done = g.run_end && s.fin;
            g.err = g.run_end ? s.err : lzss_pkg::ERR_NONE;
            g.total = 16'(count_start + r * 4 + cnt);
            res.push_back(g);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stream planning
    // ------------------------------------------------------------------
    // What the next byte will be taken as, after pending flag bits are used
    function automatic int next_role(input logic [15:0] fw, input int left,
                                     input lzss_pkg::phase_t ph);
        bit fb;
        while (left != 0 && ph <= lzss_pkg::PH_SLEN_LO) begin
            fb = fw[0];
            fw = fw >> 1;
            left--;
            case (ph)
                lzss_pkg::PH_TYPE:    ph = fb ? lzss_pkg::PH_LIT : lzss_pkg::PH_KIND;
                lzss_pkg::PH_KIND:    ph = fb ? lzss_pkg::PH_LB1 : lzss_pkg::PH_SLEN_HI;
                lzss_pkg::PH_SLEN_HI: ph = lzss_pkg::PH_SLEN_LO;
                default:              ph = lzss_pkg::PH_SDIST;
            endcase
        end
        return (left == 0) ? ROLE_FLAG : int'(ph);
    endfunction

    function automatic int pick_dist(int cap);
        int maxd;
        if (pin_dist.size() != 0) return pin_dist.pop_front();
        if (end_mode == END_DIST && plan.wcount < cap) return plan.wcount + 1;
        maxd = (plan.wcount < cap) ? plan.wcount : cap;
        if (maxd == 0) return 1;
        // short distances favor overlapping copies
        if ($urandom_range(0, 1) == 0) return $urandom_range(1, (maxd < 4) ? maxd : 4);
        return $urandom_range(1, maxd);
    endfunction

    function automatic logic [7:0] plan_byte(int role);
        int         d;
        int         roll;
        logic [2:0] len3;
        roll = $urandom_range(0, 99);
        if (role == ROLE_FLAG) return (plan.wcount < 8) ? 8'hFF : 8'($urandom);
        case (role)
            int'(lzss_pkg::PH_LIT):
                return (roll < 5) ? 8'h00 : (roll < 10) ? 8'hFF : 8'($urandom);
            int'(lzss_pkg::PH_SDIST): begin
                d = pick_dist(256);
                return 8'(256 - d);
            end
            int'(lzss_pkg::PH_LB1): begin
                d = pick_dist(8192);
                long_code = 13'(8192 - d);
                return long_code[7:0];
            end
            int'(lzss_pkg::PH_LB2): begin
                if (pin_len3.size() != 0) len3 = 3'(pin_len3.pop_front());
                else if (end_mode == END_MARK) len3 = 3'd0;
                else len3 = 3'($urandom_range(0, 7));
                return {long_code[12:8], len3};
            end
            default: begin
                // extension byte
                if (pin_ext.size() != 0) return 8'(pin_ext.pop_front());
                if (end_mode == END_MARK) return 8'h00;
                if (roll < 20) return 8'h01;
                if (roll < 23) return 8'hFF;
                return 8'($urandom_range(2, 40));
            end
        endcase
    endfunction

    task automatic queue_plain(input logic [7:0] plain, input bit last);
        out_group_t dummy[$];
        logic [7:0] raw;
        raw = plain ^ plan.key;
        decode_byte(plan, raw, last, dummy);
        pending_bytes.push_back('{raw, last});
    endtask

    task automatic queue_next(input bit last);
        queue_plain(plan_byte(next_role(plan.fw, plan.left, plan.ph)), last);
    endtask

    // Wait until the block has nothing in flight, then for a flag-only byte to settle
    task automatic drain();
        do @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || expected_groups.size() != 0);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == lzss_pkg::REG_XOR_KEY) begin
            model.key = value[7:0];
            plan.key = value[7:0];
        end else begin
            model.lim = value;
            plan.lim = value;
        end
    endtask

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset and stimulus
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        logic [7:0] lits [6];
        int role;
        int n;
        bit last;
        lits = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        fail_count = 0;
        end_mode = END_NONE;
        long_code = '0;
        clear_state(model);
        clear_state(plan);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed opening under reset config: sixteen literals, the first six with edge values
        queue_plain(8'hFF, 0);
        queue_plain(8'hFF, 0);
        for (int i = 0; i < 16; i++)
            queue_plain((i < 6) ? lits[i] : 8'($urandom), 0);
        // Flags low to high: short len 5, short len 2, long, long+ext, long+ext, literals
        queue_plain(8'h0C, 0);
        queue_plain(8'hEA, 0);
        pin_dist = '{1, 16, 16, 1, 5};
        pin_len3 = '{5, 0, 0};
        pin_ext = '{255, 1};
        repeat (12) queue_next(0);

        // Random phases, config changed between them; stream stays open
        for (int p = 0; p < 7; p++) begin
            drain();
            write_reg(lzss_pkg::REG_XOR_KEY, (p == 0) ? 16'h0000 : (p == 1) ? 16'h00FF
                                                : 16'($urandom_range(0, 255)));
            write_reg(lzss_pkg::REG_OUT_LIMIT, (p == 0) ? 16'hFFFF : (p == 1) ? 16'd32768
                                                  : 16'($urandom_range(30000, 65535)));
            repeat (70) queue_next(0);
        end

        // Closing phase: end the stream one of five ways
        drain();
        end_mode = end_mode_t'($urandom_range(int'(END_NORMAL), int'(END_OVER)));
        if (end_mode == END_OVER)
            write_reg(lzss_pkg::REG_OUT_LIMIT, 16'(plan.wcount + $urandom_range(0, 5)));
        n = 0;
        while (!plan.fin) begin
            role = next_role(plan.fw, plan.left, plan.ph);
            case (end_mode)
                END_NORMAL: last = (role == int'(lzss_pkg::PH_LIT));
                END_TRUNC:  last = (role == ROLE_FLAG || role == int'(lzss_pkg::PH_LB1));
                default:    last = (n >= 300);
            endcase
            queue_plain(plan_byte(role), last);
            n++;
        end
        end_mode = END_NONE;
        // Bytes after the end only repeat the status
        repeat (4) queue_plain(8'($urandom), 1'($urandom_range(0, 1)));
        drain();
        write_reg(lzss_pkg::REG_OUT_LIMIT, 16'h0000);
        write_reg(lzss_pkg::REG_XOR_KEY, 16'($urandom_range(0, 255)));
        repeat (3) queue_plain(8'($urandom), 1'($urandom_range(0, 1)));
        drain();

        if (fail_count == 0)
            $display("lzss_flagword_decompressor_unit verification clean");
        else
            $display("lzss_flagword_decompressor_unit verification failed");
        $finish;
    end

    initial begin
        #10000000;
        $display("lzss_flagword_decompressor_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver, monitor and receiver back-pressure
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) cyc <= 0;
        else cyc <= cyc + 1;
    end

    // No idling on either side during this window
    wire calm = (cyc >= 2000 && cyc < 3500);

    always @(posedge clk or negedge rst_n) begin
        out_group_t produced[$];
        in_item_t   it;
        if (!rst_n) begin
            in_valid <= 1'b0;
            data_byte <= '0;
            last_byte <= 1'b0;
        end else begin
            if (in_valid && !in_stall) begin
                decode_byte(model, data_byte, last_byte, produced);
                foreach (produced[i]) expected_groups.push_back(produced[i]);
            end
            if (!in_valid || !in_stall) begin
                if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
                    it = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= it.data;
                    last_byte <= it.last;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off so the block backs up into its input stall
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) hold_left <= 0;
        else if (cyc == 1200) hold_left <= 400;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n) begin
        out_group_t g;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_groups.size() == 0) begin
                    $error("output transfer with no expected group (total_out %0d)", total_out);
                    fail_count++;
                end else begin
                    g = expected_groups.pop_front();
                    check_field("out_byte0", g.data[0], out_byte0);
                    check_field("out_byte1", g.data[1], out_byte1);
                    check_field("out_byte2", g.data[2], out_byte2);
                    check_field("out_byte3", g.data[3], out_byte3);
                    check_field("byte_count", g.count, byte_count);
                    check_field("run_end", g.run_end, run_end);
                    check_field("stream_done", g.done, stream_done);
                    check_field("error_code", g.err, error_code);
                    check_field("total_out", g.total, total_out);
                end
            end
            out_stall <= (hold_left > 1) || (!calm && $urandom_range(0, 99) < 24);
        end
    end

endmodule

### files.f
+incdir+sv
sv/lzss_pkg.sv
sv/lzss_flagword_decompressor_unit.sv
sim/tb.sv
